### sv/assert_macros.svh
// Assertion macros shared by the RTL files of the frame builder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge outside of reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that a condition in one cycle is followed by another in the next cycle.
`define ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error(msg);

`endif

### sv/sfb_pkg.sv
// Types and constants of the sensor frame builder.
package sfb_pkg;

  localparam int unsigned WORD_W          = 32;
  localparam int unsigned BYTE_W          = 8;
  localparam int unsigned IDX_W           = 6;
  localparam int unsigned WORDS_PER_FRAME = 21;

  localparam logic [BYTE_W-1:0] HDR_BYTE0    = 8'hAA;
  localparam logic [BYTE_W-1:0] HDR_BYTE1    = 8'h55;
  localparam logic [BYTE_W-1:0] TRAILER_BYTE = 8'h0A;

  // Position of a byte inside the sequence that one word causes.
  typedef enum logic [2:0] {
    SLOT_HDR0,
    SLOT_HDR1,
    SLOT_B0,
    SLOT_B1,
    SLOT_B2,
    SLOT_B3,
    SLOT_SUM,
    SLOT_TRL
  } slot_t;

endpackage

### sv/sensor_frame_builder.sv
// Sensor frame builder: turns 32-bit sensor words into a framed byte stream.
//
// Input channel: in_valid/in_stall carry one sensor word per beat.
// Output channel: out_valid/out_stall carry one frame byte per beat, with
// out_run_last on the last byte of a word and out_frame_last on the trailer.
// A frame is 0xAA 0x55, then each word low byte first, then the 8-bit sum of
// the payload bytes, then 0x0A. WORDS_PER_FRAME words make one frame.
// A word enters a work register, which hands one byte per cycle to the
// output register while the receiver does not stall. Its first byte follows
// the word from the work register into the output register. Throughput is set
// by the byte-wide output: four bytes per word, plus header, sum and trailer.
// The next word is taken in the cycle the current word's last byte moves
// into the output register, so there are no gaps between words.
// When the receiver stalls, the output byte holds and the work register
// stops; in_stall rises once the work register is full.
// Synchronous reset empties both registers and starts a new frame.
`include "assert_macros.svh"

module sensor_frame_builder #(
  parameter int unsigned WORDS_PER_FRAME = sfb_pkg::WORDS_PER_FRAME
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [sfb_pkg::WORD_W-1:0] in_sensor_word,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [sfb_pkg::BYTE_W-1:0] out_byte,
  output logic                      out_run_last,
  output logic                      out_frame_last
);

  localparam int unsigned CNT_W = sfb_pkg::IDX_W + 1;
  localparam logic [CNT_W-1:0] FRAME_LEN = CNT_W'(WORDS_PER_FRAME);

  // Frame state.
  logic [sfb_pkg::IDX_W-1:0]  word_index_r, word_index_nxt;
  logic [sfb_pkg::BYTE_W-1:0] running_sum_r, running_sum_nxt;

  // Work register: the word whose bytes are being sent.
  logic                       work_valid_r;
  logic [sfb_pkg::WORD_W-1:0] word_r;
  logic [sfb_pkg::BYTE_W-1:0] chk_r;
  logic                       last_r;
  sfb_pkg::slot_t             slot_r;

  // Output register.
  logic                       out_valid_r;
  logic [sfb_pkg::BYTE_W-1:0] out_byte_r;
  logic                       out_run_last_r;
  logic                       out_frame_last_r;

  logic                       in_accept;
  logic                       out_free;
  logic                       advance;
  logic                       finish;
  logic                       word_last;
  logic [sfb_pkg::BYTE_W-1:0] sum_word;
  logic [sfb_pkg::BYTE_W-1:0] cur_byte;
  sfb_pkg::slot_t             end_slot;

  assign out_free  = !out_valid_r || !out_stall;
  assign advance   = work_valid_r && out_free;
  assign end_slot  = last_r ? sfb_pkg::SLOT_TRL : sfb_pkg::SLOT_B3;
  assign finish    = advance && (slot_r == end_slot);
  assign in_stall  = work_valid_r && !finish;
  assign in_accept = in_valid && !in_stall;

  // A counter at or past the frame length also closes the frame.
  assign word_last = ({1'b0, word_index_r} + CNT_W'(1)) >= FRAME_LEN;

  assign sum_word = running_sum_r + in_sensor_word[7:0] + in_sensor_word[15:8]
                  + in_sensor_word[23:16] + in_sensor_word[31:24];

  always_comb begin
    word_index_nxt  = word_index_r;
    running_sum_nxt = running_sum_r;
    if (in_accept) begin
      if (word_last) begin
        word_index_nxt  = '0;
        running_sum_nxt = '0;
      end else begin
        word_index_nxt  = word_index_r + sfb_pkg::IDX_W'(1);
        running_sum_nxt = sum_word;
      end
    end
  end

  always_comb begin
    unique case (slot_r)
      sfb_pkg::SLOT_HDR0: cur_byte = sfb_pkg::HDR_BYTE0;
      sfb_pkg::SLOT_HDR1: cur_byte = sfb_pkg::HDR_BYTE1;
      sfb_pkg::SLOT_B0:   cur_byte = word_r[7:0];
      sfb_pkg::SLOT_B1:   cur_byte = word_r[15:8];
      sfb_pkg::SLOT_B2:   cur_byte = word_r[23:16];
      sfb_pkg::SLOT_B3:   cur_byte = word_r[31:24];
      sfb_pkg::SLOT_SUM:  cur_byte = chk_r;
      sfb_pkg::SLOT_TRL:  cur_byte = sfb_pkg::TRAILER_BYTE;
      default:            cur_byte = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_index_r  <= '0;
      running_sum_r <= '0;
      work_valid_r  <= 1'b0;
      slot_r        <= sfb_pkg::SLOT_HDR0;
      out_valid_r   <= 1'b0;
    end else begin
      word_index_r  <= word_index_nxt;
      running_sum_r <= running_sum_nxt;
      if (in_accept) begin
        work_valid_r <= 1'b1;
        slot_r       <= (word_index_r == '0) ? sfb_pkg::SLOT_HDR0 : sfb_pkg::SLOT_B0;
      end else begin
        if (finish) begin
          work_valid_r <= 1'b0;
        end
        if (advance) begin
          slot_r <= sfb_pkg::slot_t'(slot_r + 3'd1);
        end
      end
      if (out_free) begin
        out_valid_r <= work_valid_r;
      end
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      word_r <= in_sensor_word;
      chk_r  <= sum_word;
      last_r <= word_last;
    end
    if (out_free) begin
      out_byte_r       <= cur_byte;
      out_run_last_r   <= (slot_r == end_slot);
      out_frame_last_r <= (slot_r == sfb_pkg::SLOT_TRL);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_byte       = out_byte_r;
  assign out_run_last   = out_run_last_r;
  assign out_frame_last = out_frame_last_r;

  `ASSERT_CLK(a_frame_last_ends_run, !(out_valid_r && out_frame_last_r) || out_run_last_r, "frame end without run end")
  `ASSERT_CLK(a_frame_last_trailer, !(out_valid_r && out_frame_last_r) || (out_byte_r == sfb_pkg::TRAILER_BYTE), "frame end is not the trailer")
  `ASSERT_CLK(a_index_in_frame, {1'b0, word_index_r} < FRAME_LEN, "word index past frame length")
  `ASSERT_NEXT(a_accept_fills_work, in_accept, work_valid_r, "accepted word lost")

endmodule

### test/sensor_frame_builder_tb.sv
// Self-checking testbench for the sensor frame builder: directed and random words in, framed bytes checked.
module sensor_frame_builder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WPF         = sfb_pkg::WORDS_PER_FRAME;
  localparam int RAND_WORDS  = 206;
  localparam int DRAIN_CYCLES = 16;
  localparam int CYCLE_LIMIT = 200000;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [sfb_pkg::BYTE_W-1:0] data;
    logic                       run_last;
    logic                       frame_last;
  } frame_byte_t;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        in_valid = 1'b0;
  logic                        in_stall;
  logic [sfb_pkg::WORD_W-1:0]  in_sensor_word = '0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic [sfb_pkg::BYTE_W-1:0]  out_byte;
  logic                        out_run_last;
  logic                        out_frame_last;

  logic [sfb_pkg::WORD_W-1:0]  word_q[$];
  frame_byte_t                 frame_bytes_q[$];
  logic [sfb_pkg::IDX_W-1:0]   pred_word_idx;
  logic [sfb_pkg::BYTE_W-1:0]  pred_sum;
  int                          err_cnt = 0;
  int                          cycle_cnt = 0;
  int                          burst_left;
  int                          gap_left;
  int                          stall_kind;
  int                          stall_left;

  sensor_frame_builder #(.WORDS_PER_FRAME(WPF)) u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_sensor_word (in_sensor_word),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .out_run_last   (out_run_last),
    .out_frame_last (out_frame_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Appends the bytes that one accepted word produces and advances the frame state.
  task automatic queue_word_bytes(input logic [sfb_pkg::WORD_W-1:0] w);
    frame_byte_t tmp[8];
    int          n;
    logic [sfb_pkg::BYTE_W-1:0] b;
    n = 0;
    if (pred_word_idx == '0) begin
      tmp[n] = '{sfb_pkg::HDR_BYTE0, 1'b0, 1'b0};
      n = n + 1;
      tmp[n] = '{sfb_pkg::HDR_BYTE1, 1'b0, 1'b0};
      n = n + 1;
    end
    for (int k = 0; k < 4; k++) begin
      b = w[8*k +: 8];
      pred_sum = pred_sum + b;
      tmp[n] = '{b, 1'b0, 1'b0};
      n = n + 1;
    end
    if (int'(pred_word_idx) + 1 >= WPF) begin
      tmp[n] = '{pred_sum, 1'b0, 1'b0};
      n = n + 1;
      tmp[n] = '{sfb_pkg::TRAILER_BYTE, 1'b0, 1'b1};
      n = n + 1;
      pred_word_idx = '0;
      pred_sum = '0;
    end else begin
      pred_word_idx = pred_word_idx + 1'b1;
    end
    tmp[n-1].run_last = 1'b1;
    for (int k = 0; k < n; k++) frame_bytes_q.push_back(tmp[k]);
  endtask

  function automatic logic [sfb_pkg::WORD_W-1:0] rand_word();
    logic [sfb_pkg::WORD_W-1:0] w;
    w = '0;
    case ($urandom_range(0, 5))
      0, 1: w = $urandom;
      2: begin
        // Bytes at the extremes stress the checksum wrap.
        for (int k = 0; k < 4; k++) begin
          case ($urandom_range(0, 2))
            0: w[8*k +: 8] = 8'h00;
            1: w[8*k +: 8] = 8'hFF;
            default: w[8*k +: 8] = 8'($urandom);
          endcase
        end
      end
      3: w = sfb_pkg::WORD_W'($urandom_range(0, 255));
      4: w = ~(sfb_pkg::WORD_W'(1) << $urandom_range(0, 31));
      default: w = $urandom_range(0, 1) ? '1 : '0;
    endcase
    return w;
  endfunction

  initial begin
    word_q.push_back(32'h0000_0000);
    word_q.push_back(32'hFFFF_FFFF);
    word_q.push_back(32'h8000_0000);
    word_q.push_back(32'h0000_0001);
    word_q.push_back(32'h7FFF_FFFF);
    // The rest of the first frame is all ones, so the sum wraps many times.
    for (int k = 5; k < WPF; k++) word_q.push_back(32'hFFFF_FFFF);
    word_q.push_back(32'h1234_5678);
    word_q.push_back(32'hAA55_AA55);
    word_q.push_back(32'h0A0A_0A0A);
    for (int k = 0; k < RAND_WORDS; k++) word_q.push_back(rand_word());

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    // Checking at the falling edge sees the driver's and monitor's updates settled.
    while (word_q.size() != 0 || in_valid) @(negedge clk);
    while (frame_bytes_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (frame_bytes_q.size() != 0) err_cnt = err_cnt + frame_bytes_q.size();
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d bytes outstanding", cycle_cnt,
               frame_bytes_q.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Driver: sends words in bursts separated by random gaps.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid       <= 1'b0;
      in_sensor_word <= '0;
      pred_word_idx  = '0;
      pred_sum       = '0;
      burst_left     = $urandom_range(1, 40);
      gap_left       = 0;
    end else begin
      if (in_valid && !in_stall) queue_word_bytes(in_sensor_word);
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left = gap_left - 1;
          in_valid <= 1'b0;
        end else if (word_q.size() != 0) begin
          in_valid       <= 1'b1;
          in_sensor_word <= word_q.pop_front();
          burst_left = burst_left - 1;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left   = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 9);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each accepted byte and drives the receiver's stall pattern.
  always @(posedge clk) begin
    frame_byte_t exp_b;
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_kind = 0;
      stall_left = $urandom_range(20, 80);
    end else begin
      if (out_valid && !out_stall) begin
        if (frame_bytes_q.size() == 0) begin
          err_cnt = err_cnt + 1;
          if (err_cnt <= MAX_REPORTS)
            $display("%0t: unexpected byte %02h run_last %b frame_last %b", $realtime,
                     out_byte, out_run_last, out_frame_last);
        end else begin
          exp_b = frame_bytes_q.pop_front();
          if (out_byte !== exp_b.data || out_run_last !== exp_b.run_last ||
              out_frame_last !== exp_b.frame_last) begin
            err_cnt = err_cnt + 1;
            if (err_cnt <= MAX_REPORTS)
              $display("%0t: expected byte %02h rl %b fl %b, got %02h rl %b fl %b",
                       $realtime, exp_b.data, exp_b.run_last, exp_b.frame_last,
                       out_byte, out_run_last, out_frame_last);
          end
        end
      end
      if (stall_left == 0) begin
        stall_kind = $urandom_range(0, 2);
        stall_left = stall_kind == 2 ? $urandom_range(1, 12) : $urandom_range(10, 80);
      end
      stall_left = stall_left - 1;
      case (stall_kind)
        0: out_stall <= 1'b0;
        1: out_stall <= 1'($urandom_range(0, 1));
        default: out_stall <= 1'b1;
      endcase
    end
  end

endmodule
